/* sv/rau_pkg.sv */
// Package for the rational arithmetic unit: operation codes and field widths.
// No dependencies.
package rau_pkg;

    localparam int FIELD_W = 32;
    localparam int FUNC_W  = 3;

    typedef logic [FUNC_W-1:0] func_t;

    localparam func_t FUNC_ADD = 3'd0;
    localparam func_t FUNC_SUB = 3'd1;
    localparam func_t FUNC_MUL = 3'd2;
    localparam func_t FUNC_DIV = 3'd3;
    localparam func_t FUNC_RED = 3'd4;

endpackage

/* sv/rational_arithmetic_unit_core.sv */
// Rational arithmetic unit: add/sub/mul/div by cross-multiplication, reduce by gcd.
// One shared multiplier, one shared subtractor (binary gcd, restoring divide).
// Depends on rau_pkg.
//
//  channel   handshake           payload
//  input     start / busy        func, first_/second_ numerator/denominator
//  result    done (strobe)       result_numerator, result_denominator,
//                                overflow, zero_divisor
//
// Add and subtract pass through S_MUL0, S_MUL1 and S_MUL2 before S_FINISH,
// multiply and divide through S_MUL0 and S_MUL1; a zero-denominator reduce
// or an unused code goes straight to S_FINISH. With a nonzero denominator,
// reduce runs the binary gcd loop on the shared subtractor, then two divisions.
// Reset clears the sequencer and the done strobe. The receiver cannot stall;
// a new word may start in the cycle that done is shown.
module rational_arithmetic_unit_core #(
    parameter int WORD_BITS = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  rau_pkg::func_t                      func,
    input  logic signed [rau_pkg::FIELD_W-1:0]  first_numerator,
    input  logic signed [rau_pkg::FIELD_W-1:0]  first_denominator,
    input  logic signed [rau_pkg::FIELD_W-1:0]  second_numerator,
    input  logic signed [rau_pkg::FIELD_W-1:0]  second_denominator,
    output logic                                done,
    output logic signed [rau_pkg::FIELD_W-1:0]  result_numerator,
    output logic signed [rau_pkg::FIELD_W-1:0]  result_denominator,
    output logic                                overflow,
    output logic                                zero_divisor
);

    localparam int OB = (WORD_BITS < rau_pkg::FIELD_W) ? WORD_BITS : rau_pkg::FIELD_W;
    localparam int PW = 2 * OB;
    localparam int AW = (PW + 1 > WORD_BITS + 1) ? PW + 1 : WORD_BITS + 1;
    localparam int CW = $clog2(OB + 1);
    localparam int HW = AW - WORD_BITS + 1;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_MUL0   = 3'd1;
    localparam logic [2:0] S_MUL1   = 3'd2;
    localparam logic [2:0] S_MUL2   = 3'd3;
    localparam logic [2:0] S_GCD    = 3'd4;
    localparam logic [2:0] S_DIVA   = 3'd5;
    localparam logic [2:0] S_DIVB   = 3'd6;
    localparam logic [2:0] S_FINISH = 3'd7;

    logic [2:0]             state_reg, state_next;
    rau_pkg::func_t         func_reg;
    logic signed [OB-1:0]   a_reg, b_reg, c_reg, d_reg;
    logic signed [PW-1:0]   pr_reg;
    logic signed [AW-1:0]   acc_reg;
    logic [OB-1:0]          x_reg, y_reg, rem_reg, qa_reg;
    logic [CW-1:0]          k_reg, cnt_reg;
    logic                   zdiv_reg;
    logic                   done_reg, ovf_reg, zd_out_reg;
    logic signed [rau_pkg::FIELD_W-1:0] num_out_reg, den_out_reg;

    logic                   accept;
    logic signed [OB-1:0]   in_a, in_b, in_c, in_d;
    logic [OB-1:0]          in_mag_a, in_mag_b, mag_a;
    logic signed [OB-1:0]   mul_a, mul_b;
    logic signed [PW-1:0]   prod;
    logic [OB:0]            sub_a, sub_b, diff;
    logic [OB:0]            shifted;
    logic                   qbit;
    logic [OB-1:0]          qnext;
    logic [AW-1:0]          qa_ext;
    logic [PW-1:0]          qb_ext;
    logic signed [AW-1:0]   den_ext;
    logic [HW-1:0]          num_hi, den_hi;
    logic                   ovf_calc;

    assign accept = start && (state_reg == S_IDLE);
    assign busy   = (state_reg != S_IDLE);

    assign in_a = first_numerator[OB-1:0];
    assign in_b = first_denominator[OB-1:0];
    assign in_c = second_numerator[OB-1:0];
    assign in_d = second_denominator[OB-1:0];

    assign in_mag_a = in_a[OB-1] ? (~in_a + 1'b1) : in_a;
    assign in_mag_b = in_b[OB-1] ? (~in_b + 1'b1) : in_b;
    assign mag_a    = a_reg[OB-1] ? (~a_reg + 1'b1) : a_reg;

    // shared multiplier
    always_comb
    begin
        unique case (state_reg)
            S_MUL0:
            begin
                mul_a = a_reg;
                mul_b = (func_reg == rau_pkg::FUNC_MUL) ? c_reg : d_reg;
            end
            S_MUL1:
            begin
                mul_a = (func_reg == rau_pkg::FUNC_MUL) ? b_reg : c_reg;
                mul_b = (func_reg == rau_pkg::FUNC_MUL) ? d_reg : b_reg;
            end
            default:
            begin
                mul_a = b_reg;
                mul_b = d_reg;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    // shared subtractor: gcd compare or restoring-divide trial
    assign shifted = {rem_reg, x_reg[OB-1]};

    always_comb
    begin
        if (state_reg == S_GCD)
        begin
            sub_a = {1'b0, x_reg};
            sub_b = {1'b0, y_reg};
        end
        else
        begin
            sub_a = shifted;
            sub_b = {1'b0, y_reg};
        end
    end

    assign diff   = sub_a - sub_b;
    assign qbit   = ~diff[OB];
    assign qnext  = {x_reg[OB-2:0], qbit};
    assign qa_ext = {{(AW-OB){1'b0}}, qa_reg};
    assign qb_ext = {{(PW-OB){1'b0}}, qnext};

    // range check and wrap
    assign den_ext  = AW'(pr_reg);
    assign num_hi   = acc_reg[AW-1:WORD_BITS-1];
    assign den_hi   = den_ext[AW-1:WORD_BITS-1];
    assign ovf_calc = !((&num_hi) || !(|num_hi)) || !((&den_hi) || !(|den_hi));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (func == rau_pkg::FUNC_ADD || func == rau_pkg::FUNC_SUB ||
                        func == rau_pkg::FUNC_MUL || func == rau_pkg::FUNC_DIV)
                        state_next = S_MUL0;
                    else if (func == rau_pkg::FUNC_RED && in_b != '0)
                        state_next = S_GCD;
                    else
                        state_next = S_FINISH;
                end
            end
            S_MUL0:
                state_next = S_MUL1;
            S_MUL1:
                state_next = (func_reg == rau_pkg::FUNC_ADD || func_reg == rau_pkg::FUNC_SUB)
                             ? S_MUL2 : S_FINISH;
            S_MUL2:
                state_next = S_FINISH;
            S_GCD:
                if (x_reg == '0)
                    state_next = S_DIVA;
            S_DIVA:
                if (cnt_reg == CW'(1))
                    state_next = S_DIVB;
            S_DIVB:
                if (cnt_reg == CW'(1))
                    state_next = S_FINISH;
            S_FINISH:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == S_FINISH);
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    func_reg <= func;
                    a_reg    <= in_a;
                    b_reg    <= in_b;
                    c_reg    <= in_c;
                    d_reg    <= in_d;
                    x_reg    <= in_mag_a;
                    y_reg    <= in_mag_b;
                    k_reg    <= '0;
                    acc_reg  <= '0;
                    pr_reg   <= '0;
                    zdiv_reg <= (func == rau_pkg::FUNC_RED) && (in_b == '0);
                end
            end
            S_MUL0:
                pr_reg <= prod;
            S_MUL1:
            begin
                acc_reg <= AW'(pr_reg);
                pr_reg  <= prod;
            end
            S_MUL2:
            begin
                if (func_reg == rau_pkg::FUNC_ADD)
                    acc_reg <= acc_reg + AW'(pr_reg);
                else
                    acc_reg <= acc_reg - AW'(pr_reg);
                pr_reg <= prod;
            end
            S_GCD:
            begin
                priority if (x_reg == '0)
                begin
                    y_reg   <= y_reg << k_reg;
                    x_reg   <= mag_a;
                    rem_reg <= '0;
                    cnt_reg <= CW'(OB);
                end
                else if (!x_reg[0] && !y_reg[0])
                begin
                    x_reg <= x_reg >> 1;
                    y_reg <= y_reg >> 1;
                    k_reg <= k_reg + 1'b1;
                end
                else if (!x_reg[0])
                    x_reg <= x_reg >> 1;
                else if (!y_reg[0])
                    y_reg <= y_reg >> 1;
                else if (diff[OB])
                begin
                    x_reg <= y_reg;
                    y_reg <= x_reg;
                end
                else
                    x_reg <= diff[OB-1:0];
            end
            S_DIVA:
            begin
                if (cnt_reg == CW'(1))
                begin
                    qa_reg  <= qnext;
                    x_reg   <= b_reg[OB-1] ? (~b_reg + 1'b1) : b_reg;
                    rem_reg <= '0;
                    cnt_reg <= CW'(OB);
                end
                else
                begin
                    rem_reg <= qbit ? diff[OB-1:0] : shifted[OB-1:0];
                    x_reg   <= qnext;
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
            S_DIVB:
            begin
                rem_reg <= qbit ? diff[OB-1:0] : shifted[OB-1:0];
                x_reg   <= qnext;
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    acc_reg <= a_reg[OB-1] ? (~qa_ext + 1'b1) : qa_ext;
                    pr_reg  <= b_reg[OB-1] ? (~qb_ext + 1'b1) : qb_ext;
                end
            end
            S_FINISH:
            begin
                num_out_reg <= rau_pkg::FIELD_W'($signed(acc_reg[WORD_BITS-1:0]));
                den_out_reg <= rau_pkg::FIELD_W'($signed(den_ext[WORD_BITS-1:0]));
                ovf_reg     <= ovf_calc;
                zd_out_reg  <= zdiv_reg;
            end
        endcase
    end

    assign done               = done_reg;
    assign result_numerator   = num_out_reg;
    assign result_denominator = den_out_reg;
    assign overflow           = ovf_reg;
    assign zero_divisor       = zd_out_reg;

    a_done_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == S_FINISH))
        else $error("done without finish step");

    a_start_takes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not raise busy");

    a_zdiv_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
        (done && zero_divisor) |->
            (result_numerator == '0 && result_denominator == '0 && !overflow))
        else $error("zero divisor result not cleared");

    a_gcd_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_GCD) |-> (y_reg != '0))
        else $error("gcd loop lost its nonzero operand");

    a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIVA || state_reg == S_DIVB) |-> (y_reg != '0))
        else $error("divide by zero gcd");

endmodule

/* verif/tb.sv */
// Testbench for rational_arithmetic_unit_core: a directed table, then random words,
// each checked against its typed table value or a built-in fraction predictor.
// Depends on rau_pkg and rational_arithmetic_unit_core.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RESET_CYCLES = 12;
    localparam int RANDOM_WORDS = 1050;
    localparam int DRAIN_CYCLES = 200;
    localparam int STALL_LIMIT  = 4000;
    localparam rau_pkg::func_t FUNC_UNUSED_5 = 3'd5;
    localparam rau_pkg::func_t FUNC_UNUSED_6 = 3'd6;
    localparam rau_pkg::func_t FUNC_UNUSED_7 = 3'd7;
    localparam logic [31:0] FIELD_MIN = 32'h8000_0000;
    localparam logic [31:0] FIELD_MAX = 32'h7fff_ffff;

    typedef struct packed {
        logic signed [rau_pkg::FIELD_W-1:0] num;
        logic signed [rau_pkg::FIELD_W-1:0] den;
        logic                               ovf;
        logic                               zdiv;
    } frac_result_t;

    typedef struct packed {
        rau_pkg::func_t                     op;
        logic signed [rau_pkg::FIELD_W-1:0] an;
        logic signed [rau_pkg::FIELD_W-1:0] ad;
        logic signed [rau_pkg::FIELD_W-1:0] bn;
        logic signed [rau_pkg::FIELD_W-1:0] bd;
        logic                               typed;
        frac_result_t                       want;
    } frac_word_t;

    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               start = 1'b0;
    logic                               busy;
    rau_pkg::func_t                     func = rau_pkg::FUNC_ADD;
    logic signed [rau_pkg::FIELD_W-1:0] first_numerator = '0;
    logic signed [rau_pkg::FIELD_W-1:0] first_denominator = '0;
    logic signed [rau_pkg::FIELD_W-1:0] second_numerator = '0;
    logic signed [rau_pkg::FIELD_W-1:0] second_denominator = '0;
    logic                               done;
    logic signed [rau_pkg::FIELD_W-1:0] result_numerator;
    logic signed [rau_pkg::FIELD_W-1:0] result_denominator;
    logic                               overflow;
    logic                               zero_divisor;

    frac_word_t   fraction_words[$];
    frac_result_t pending_results[$];
    int           fail_count = 0;
    int           stall_cycles = 0;

    rational_arithmetic_unit_core dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .start              (start),
        .busy               (busy),
        .func               (func),
        .first_numerator    (first_numerator),
        .first_denominator  (first_denominator),
        .second_numerator   (second_numerator),
        .second_denominator (second_denominator),
        .done               (done),
        .result_numerator   (result_numerator),
        .result_denominator (result_denominator),
        .overflow           (overflow),
        .zero_divisor       (zero_divisor)
    );

    always #5 clk = ~clk;

    function automatic bit fits_field(longint v);
        return v == longint'(int'(v));
    endfunction

    function automatic frac_result_t fraction_result(frac_word_t w);
        longint a, b, c, d, p, q, s, num, den;
        longint unsigned ma, mb, x, y, t;
        frac_result_t r;
        a = w.an;
        b = w.ad;
        c = w.bn;
        d = w.bd;
        num = 0;
        den = 0;
        r = '0;
        case (w.op)
            rau_pkg::FUNC_ADD, rau_pkg::FUNC_SUB:
            begin
                p = a * d;
                q = c * b;
                if (w.op == rau_pkg::FUNC_SUB)
                    q = -q;
                s = p + q;
                num = s;
                den = b * d;
                r.ovf = ((p[63] == q[63]) && (s[63] != p[63]))
                        || !fits_field(num) || !fits_field(den);
            end
            rau_pkg::FUNC_MUL, rau_pkg::FUNC_DIV:
            begin
                num = (w.op == rau_pkg::FUNC_MUL) ? a * c : a * d;
                den = (w.op == rau_pkg::FUNC_MUL) ? b * d : c * b;
                r.ovf = !fits_field(num) || !fits_field(den);
            end
            rau_pkg::FUNC_RED:
            begin
                if (b == 0)
                    r.zdiv = 1'b1;
                else
                begin
                    ma = (a < 0) ? -a : a;
                    mb = (b < 0) ? -b : b;
                    x = ma;
                    y = mb;
                    while (y != 0)
                    begin
                        t = x % y;
                        x = y;
                        y = t;
                    end
                    num = (a < 0) ? -longint'(ma / x) : longint'(ma / x);
                    den = (b < 0) ? -longint'(mb / x) : longint'(mb / x);
                end
            end
            default: ;
        endcase
        r.num = num[31:0];
        r.den = den[31:0];
        return r;
    endfunction

    task automatic table_row(rau_pkg::func_t op, logic [31:0] an, ad, bn, bd,
                             bit typed = 1'b0,
                             logic [31:0] num = '0, logic [31:0] den = '0,
                             logic ovf = 1'b0, logic zdiv = 1'b0);
        frac_word_t w;
        w.op = op;
        w.an = an;
        w.ad = ad;
        w.bn = bn;
        w.bd = bd;
        w.typed = typed;
        w.want = '{num: num, den: den, ovf: ovf, zdiv: zdiv};
        fraction_words.push_back(w);
    endtask

    function automatic logic [31:0] random_operand();
        logic [31:0] v;
        case ($urandom_range(0, 9))
            0: v = '0;
            1:
            begin
                case ($urandom_range(0, 3))
                    0: v = FIELD_MIN;
                    1: v = FIELD_MAX;
                    2: v = '1;
                    default: v = 32'd1;
                endcase
            end
            2, 3, 4: v = $urandom_range(0, 2000) - 1000;
            default: v = $urandom();
        endcase
        return v;
    endfunction

    task automatic add_random_word();
        frac_word_t w;
        int unsigned pick;
        int g;
        pick = $urandom_range(0, 99);
        w = '0;
        w.op = (pick < 90) ? rau_pkg::func_t'(pick % 5) : rau_pkg::func_t'(5 + pick % 3);
        w.an = random_operand();
        w.ad = random_operand();
        w.bn = random_operand();
        w.bd = random_operand();
        // shared factor so the gcd is usually more than one
        if (w.op == rau_pkg::FUNC_RED && $urandom_range(0, 9) < 6)
        begin
            g = $urandom_range(1, 4096);
            w.an = g * (int'($urandom_range(0, 60000)) - 30000);
            w.ad = g * (int'($urandom_range(1, 30000)) * ($urandom_range(0, 1) ? 1 : -1));
        end
        fraction_words.push_back(w);
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $realtime, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        frac_result_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %h/%h ovf %b zdiv %b",
                         $realtime, result_numerator, result_denominator, overflow,
                         zero_divisor);
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("result_numerator", want.num, result_numerator);
                check_field("result_denominator", want.den, result_denominator);
                check_field("overflow", want.ovf, overflow);
                check_field("zero_divisor", want.zdiv, zero_divisor);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        int idx;
        bit hold;
        // plain fractions
        table_row(rau_pkg::FUNC_ADD, 1, 2, 1, 3, 1, 5, 6);
        table_row(rau_pkg::FUNC_SUB, 1, 2, 1, 3, 1, 1, 6);
        table_row(rau_pkg::FUNC_MUL, 2, 3, 4, 5, 1, 8, 15);
        table_row(rau_pkg::FUNC_DIV, 2, 3, 4, 5, 1, 10, 12);
        // reduce: signs, zero numerator, zero denominator, most negative values
        table_row(rau_pkg::FUNC_RED, 6, 4, 9, 9, 1, 3, 2);
        table_row(rau_pkg::FUNC_RED, -6, 4, 0, 0, 1, -3, 2);
        table_row(rau_pkg::FUNC_RED, 6, -4, 0, 0, 1, 3, -2);
        table_row(rau_pkg::FUNC_RED, 0, -5, 0, 0, 1, 0, -1);
        table_row(rau_pkg::FUNC_RED, 7, 0, 1, 1, 1, 0, 0, 1'b0, 1'b1);
        table_row(rau_pkg::FUNC_RED, 0, 0, 0, 0, 1, 0, 0, 1'b0, 1'b1);
        table_row(rau_pkg::FUNC_RED, FIELD_MIN, FIELD_MIN, 0, 0, 1, -1, -1);
        table_row(rau_pkg::FUNC_RED, 5, FIELD_MIN, 0, 0, 1, 5, FIELD_MIN);
        table_row(rau_pkg::FUNC_RED, FIELD_MAX, 1, FIELD_MAX, FIELD_MAX, 1, FIELD_MAX, 1);
        // unused codes
        table_row(FUNC_UNUSED_5, 3, 4, 5, 6, 1);
        table_row(FUNC_UNUSED_6, FIELD_MAX, FIELD_MIN, FIELD_MAX, FIELD_MIN, 1);
        table_row(FUNC_UNUSED_7, '1, '1, '1, '1, 1);
        // overflow and wrap
        table_row(rau_pkg::FUNC_MUL, FIELD_MAX, 1, FIELD_MAX, 1, 1, 1, 1, 1'b1);
        table_row(rau_pkg::FUNC_MUL, FIELD_MIN, 1, FIELD_MIN, 1, 1, 0, 1, 1'b1);
        table_row(rau_pkg::FUNC_ADD, FIELD_MIN, FIELD_MIN, FIELD_MIN, FIELD_MIN, 1, 0, 0,
                  1'b1);
        table_row(rau_pkg::FUNC_SUB, FIELD_MIN, 1, FIELD_MAX, 1, 1, 1, 1, 1'b1);
        table_row(rau_pkg::FUNC_ADD, FIELD_MAX, 1, 1, 1, 1, FIELD_MIN, 1, 1'b1);
        // zero denominators pass through arithmetic, then two rows for the predictor
        table_row(rau_pkg::FUNC_DIV, 3, 4, 0, 5, 1, 15, 0);
        table_row(rau_pkg::FUNC_ADD, 1, 0, 1, 2, 1, 2, 0);
        table_row(rau_pkg::FUNC_MUL, 32'h0001_0000, 3, 32'h0001_0000, -7);
        table_row(rau_pkg::FUNC_RED, 32'h7fff_fffe, 32'h3fff_ffff, 0, 0);
        repeat (RANDOM_WORDS)
            add_random_word();

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        idx = 0;
        hold = 1'b0;
        while (idx < fraction_words.size())
        begin
            @(posedge clk);
            if (start && !busy)
            begin
                pending_results.push_back(fraction_words[idx].typed ?
                                          fraction_words[idx].want :
                                          fraction_result(fraction_words[idx]));
                idx++;
                hold = 1'b0;
            end
            else if (start)
                hold = 1'b1;
            // words 400..649 go back to back
            if (idx < fraction_words.size() &&
                (hold || (idx >= 400 && idx < 650) || $urandom_range(0, 99) >= 32))
            begin
                start <= 1'b1;
                func <= fraction_words[idx].op;
                first_numerator <= fraction_words[idx].an;
                first_denominator <= fraction_words[idx].ad;
                second_numerator <= fraction_words[idx].bn;
                second_denominator <= fraction_words[idx].bd;
            end
            else
                start <= 1'b0;
        end
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
